>>> src/utf8_stream_decoder_macros.svh
// Assertion macros shared by the UTF-8 stream decoder modules.
// No dependencies; included by each module that carries assertions.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// Implication within the same cycle, disabled during reset.
`define USD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following cycle, disabled during reset.
`define USD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define USD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define USD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/usd_pkg.sv
// Shared types, constants and helper functions of the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
package usd_pkg;

    localparam int CNT_W = 3;
    localparam int CP_W = 31;
    localparam int BYTE_W = 8;
    localparam int VALUE_BITS = 6;
    localparam int DEFAULT_MAX_SEQUENCE_BYTES = 6;

    localparam logic [CP_W-1:0] REPLACEMENT = 31'h3F;
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_VALUE_MASK = 8'h7F;

    // Everything one input byte produces: a number of replacements for the
    // closed sequence, then at most one further result.
    typedef struct packed {
        logic [CNT_W-1:0] flush_n;
        logic             tail_valid;
        logic [CP_W-1:0]  tail_cp;
        logic [CNT_W-1:0] tail_count;
        logic             tail_err;
    } run_desc_t;

    function automatic logic [3:0] leading_ones(input logic [BYTE_W-1:0] b);
        logic [3:0] k;
        logic       stop;
        k = 4'd0;
        stop = 1'b0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (!stop && b[i])
            begin
                k = k + 4'd1;
            end
            else
            begin
                stop = 1'b1;
            end
        end
        return k;
    endfunction

endpackage

>>> src/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: input register and block wiring.
// Depends on usd_pkg, usd_decode and usd_emit.

// UTF-8 stream decoder. Bytes of a text arrive on the byte channel, with
// end_of_text set on the final byte; decoded code points leave on the cp
// channel, one result per beat. Plain text, where each byte yields one result
// or none, runs at one byte per clock while the receiver does not stall; a
// byte that yields n results (replacements for a broken or unfinished
// sequence, then its own result) holds the single result port until all n
// are sent, up to six, while the next byte waits in the input register. A
// byte passes the input register and is held in the result registers before
// its first result is offered. Malformed input gives '?' (0x3F) with
// is_error set, one per byte involved; last_of_run marks the final result
// caused by a byte. Overlong and surrogate forms are passed through undetected.
module utf8_stream_decoder #(
    parameter int MAX_SEQUENCE_BYTES = usd_pkg::DEFAULT_MAX_SEQUENCE_BYTES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_stall,
    input  logic [usd_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        end_of_text,
    output logic                        cp_valid,
    input  logic                        cp_stall,
    output logic [usd_pkg::CP_W-1:0]    code_point,
    output logic [usd_pkg::CNT_W-1:0]   byte_count,
    output logic                        is_error,
    output logic                        last_of_run
);
    import usd_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              eot_reg;

    run_desc_t desc;
    logic      desc_empty;
    logic      run_free;
    logic      advance;
    logic      byte_fire;

    // A byte with no results only updates the sequence state, so it may
    // advance even while a run is still going out.
    assign desc_empty = (desc.flush_n == '0) && !desc.tail_valid;
    assign advance = in_valid_reg && (run_free || desc_empty);
    assign byte_stall = in_valid_reg && !advance;
    assign byte_fire = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_fire)
        begin
            byte_reg <= data_byte;
            eot_reg <= end_of_text;
        end
    end

    usd_decode #(
        .MAX_SEQUENCE_BYTES(MAX_SEQUENCE_BYTES)
    ) u_decode (
        .clk(clk),
        .rst_n(rst_n),
        .advance(advance),
        .data_byte(byte_reg),
        .end_of_text(eot_reg),
        .desc(desc)
    );

    usd_emit u_emit (
        .clk(clk),
        .rst_n(rst_n),
        .load(advance && !desc_empty),
        .desc(desc),
        .run_free(run_free),
        .cp_valid(cp_valid),
        .cp_stall(cp_stall),
        .code_point(code_point),
        .byte_count(byte_count),
        .is_error(is_error),
        .last_of_run(last_of_run)
    );

endmodule

>>> src/usd_decode.sv
// Sequence state and per-byte decode logic of the UTF-8 stream decoder.
// Depends on usd_pkg and utf8_stream_decoder_macros.svh.
`include "utf8_stream_decoder_macros.svh"

module usd_decode #(
    parameter int MAX_SEQUENCE_BYTES = usd_pkg::DEFAULT_MAX_SEQUENCE_BYTES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [usd_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        end_of_text,
    output usd_pkg::run_desc_t          desc
);
    import usd_pkg::*;

    logic [CNT_W-1:0] exp_len_reg, exp_len_next;
    logic [CNT_W-1:0] taken_reg, taken_next;
    logic [CP_W-1:0]  acc_reg, acc_next;

    logic             seq_open;
    logic             is_cont;
    logic [CNT_W-1:0] taken_inc;
    logic [CP_W-1:0]  acc_ext;
    logic [3:0]       ones;

    assign seq_open = (exp_len_reg != '0);
    assign is_cont = ((data_byte & CONT_MASK) == CONT_TAG);
    assign taken_inc = taken_reg + CNT_W'(1);
    assign acc_ext = {acc_reg[CP_W-VALUE_BITS-1:0], data_byte[VALUE_BITS-1:0]};
    assign ones = leading_ones(data_byte);

    always_comb
    begin
        logic fresh;
        fresh = 1'b1;
        exp_len_next = exp_len_reg;
        taken_next = taken_reg;
        acc_next = acc_reg;
        desc.flush_n = '0;
        desc.tail_valid = 1'b0;
        desc.tail_cp = REPLACEMENT;
        desc.tail_count = CNT_W'(1);
        desc.tail_err = 1'b1;

        if (seq_open)
        begin
            if (is_cont)
            begin
                fresh = 1'b0;
                if (taken_inc >= exp_len_reg)
                begin
                    desc.tail_valid = 1'b1;
                    desc.tail_cp = acc_ext;
                    desc.tail_count = exp_len_reg;
                    desc.tail_err = 1'b0;
                    exp_len_next = '0;
                    taken_next = '0;
                    acc_next = '0;
                end
                else if (end_of_text)
                begin
                    desc.flush_n = taken_inc;
                    exp_len_next = '0;
                    taken_next = '0;
                    acc_next = '0;
                end
                else
                begin
                    taken_next = taken_inc;
                    acc_next = acc_ext;
                end
            end
            else
            begin
                // The breaking byte closes the sequence and is decoded anew.
                desc.flush_n = taken_reg;
                exp_len_next = '0;
                taken_next = '0;
                acc_next = '0;
            end
        end

        if (fresh)
        begin
            if (ones == 4'd0)
            begin
                desc.tail_valid = 1'b1;
                desc.tail_cp = CP_W'(data_byte);
                desc.tail_count = CNT_W'(1);
                desc.tail_err = 1'b0;
            end
            else if (ones >= 4'd2 && ones <= 4'(MAX_SEQUENCE_BYTES))
            begin
                if (end_of_text)
                begin
                    desc.tail_valid = 1'b1;
                end
                else
                begin
                    exp_len_next = CNT_W'(ones);
                    taken_next = CNT_W'(1);
                    acc_next = CP_W'(data_byte & (LEAD_VALUE_MASK >> ones));
                end
            end
            else
            begin
                desc.tail_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= '0;
            taken_reg <= '0;
            acc_reg <= '0;
        end
        else if (advance)
        begin
            exp_len_reg <= exp_len_next;
            taken_reg <= taken_next;
            acc_reg <= acc_next;
        end
    end

    `USD_ASSERT_IMPL(a_open_taken_range, clk, rst_n, exp_len_reg != '0, taken_reg != '0 && taken_reg < exp_len_reg, "open sequence has a bad byte count")
    `USD_ASSERT_IMPL(a_closed_clean, clk, rst_n, exp_len_reg == '0, taken_reg == '0 && acc_reg == '0, "closed sequence left state behind")
    `USD_ASSERT_NEXT(a_cont_keeps_len, clk, rst_n, advance && seq_open && is_cont && !end_of_text && taken_inc < exp_len_reg, exp_len_reg == $past(exp_len_reg) && taken_reg == $past(taken_inc), "continuation did not extend the open sequence")

endmodule

>>> src/usd_emit.sv
// Result sequencer: holds one byte's results and sends them one beat at a time.
// Depends on usd_pkg and utf8_stream_decoder_macros.svh.
`include "utf8_stream_decoder_macros.svh"

module usd_emit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  usd_pkg::run_desc_t          desc,
    output logic                        run_free,
    output logic                        cp_valid,
    input  logic                        cp_stall,
    output logic [usd_pkg::CP_W-1:0]    code_point,
    output logic [usd_pkg::CNT_W-1:0]   byte_count,
    output logic                        is_error,
    output logic                        last_of_run
);
    import usd_pkg::*;

    logic             run_valid_reg;
    logic [CNT_W-1:0] flush_reg;
    logic             tail_valid_reg;
    logic [CP_W-1:0]  tail_cp_reg;
    logic [CNT_W-1:0] tail_count_reg;
    logic             tail_err_reg;

    logic last_beat;
    logic out_fire;
    logic take;

    // Replacements for the closed sequence go out first, then the tail result.
    assign last_beat = (flush_reg == '0) || (flush_reg == CNT_W'(1) && !tail_valid_reg);
    assign out_fire = run_valid_reg && !cp_stall;
    assign run_free = !run_valid_reg || (out_fire && last_beat);
    assign take = load && run_free;

    assign cp_valid = run_valid_reg;
    assign code_point = (flush_reg != '0) ? REPLACEMENT : tail_cp_reg;
    assign byte_count = (flush_reg != '0) ? CNT_W'(1) : tail_count_reg;
    assign is_error = (flush_reg != '0) || tail_err_reg;
    assign last_of_run = last_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            flush_reg <= '0;
            tail_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            run_valid_reg <= 1'b1;
            flush_reg <= desc.flush_n;
            tail_valid_reg <= desc.tail_valid;
        end
        else if (out_fire)
        begin
            if (last_beat)
            begin
                run_valid_reg <= 1'b0;
            end
            if (flush_reg != '0)
            begin
                flush_reg <= flush_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tail_cp_reg <= desc.tail_cp;
            tail_count_reg <= desc.tail_count;
            tail_err_reg <= desc.tail_err;
        end
    end

    `USD_ASSERT_IMPL(a_run_not_empty, clk, rst_n, run_valid_reg, flush_reg != '0 || tail_valid_reg, "held run has no results")
    `USD_ASSERT_NEXT(a_run_continues, clk, rst_n, out_fire && !last_beat, run_valid_reg && flush_reg == $past(flush_reg) - CNT_W'(1), "run lost a beat")
    `USD_ASSERT_NEXT(a_stall_holds_run, clk, rst_n, run_valid_reg && cp_stall, run_valid_reg && flush_reg == $past(flush_reg), "stalled run changed")

endmodule

>>> sim/tb_utf8_stream_decoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_decoder: directed and random byte texts
// with random idling on both channels. Depends on usd_pkg and the decoder RTL.

module tb_utf8_stream_decoder;

    import usd_pkg::*;

    localparam int MAX_SEQ = DEFAULT_MAX_SEQUENCE_BYTES;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_BYTES = 175;

    typedef struct {
        logic [CP_W-1:0]  value;
        logic [CNT_W-1:0] count;
        logic             err;
        logic             last;
    } cp_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              byte_valid = 1'b0;
    logic              byte_stall;
    logic [BYTE_W-1:0] data_byte = '0;
    logic              end_of_text = 1'b0;
    logic              cp_valid;
    logic              cp_stall = 1'b0;
    logic [CP_W-1:0]   code_point;
    logic [CNT_W-1:0]  byte_count;
    logic              is_error;
    logic              last_of_run;

    // Decoder state as the testbench sees it.
    logic [CNT_W-1:0]  open_len = '0;
    logic [CNT_W-1:0]  open_taken = '0;
    logic [CP_W-1:0]   open_value = '0;

    cp_result_t        cp_expected[$];
    cp_result_t        want;
    int                mismatches = 0;
    int                bytes_sent = 0;
    int                cycle_count = 0;
    int                hold_request = 0;
    int                stall_left = 0;
    logic              no_idle = 1'b0;

    utf8_stream_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .cp_valid    (cp_valid),
        .cp_stall    (cp_stall),
        .code_point  (code_point),
        .byte_count  (byte_count),
        .is_error    (is_error),
        .last_of_run (last_of_run)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 50);
    endfunction

    function automatic void push_expected(input logic [CP_W-1:0] value,
                                          input logic [CNT_W-1:0] count,
                                          input logic err);
        cp_result_t r;
        r.value = value;
        r.count = count;
        r.err = err;
        r.last = 1'b0;
        cp_expected.push_back(r);
    endfunction

    // One replacement for every byte of the open sequence, then close it.
    function automatic int close_open_sequence();
        int n;
        n = open_taken;
        for (int i = 0; i < n; i++)
            push_expected(REPLACEMENT, 3'd1, 1'b1);
        open_len = '0;
        open_taken = '0;
        open_value = '0;
        return n;
    endfunction

    task automatic predict_code_points(input logic [BYTE_W-1:0] b, input logic eot);
        int         produced;
        int         ones;
        logic       fresh;
        cp_result_t tail;
        produced = 0;
        fresh = 1'b1;
        if (open_len != 0)
        begin
            if ((b & CONT_MASK) == CONT_TAG)
            begin
                fresh = 1'b0;
                open_value = {open_value[CP_W-7:0], b[5:0]};
                open_taken = open_taken + 3'd1;
                if (open_taken >= open_len)
                begin
                    push_expected(open_value, open_len, 1'b0);
                    produced++;
                    open_len = '0;
                    open_taken = '0;
                    open_value = '0;
                end
                else if (eot)
                begin
                    produced += close_open_sequence();
                end
            end
            else
            begin
                produced += close_open_sequence();
            end
        end
        if (fresh)
        begin
            ones = 0;
            while (ones < 8 && b[7 - ones])
                ones++;
            if (ones == 0)
            begin
                push_expected(CP_W'(b), 3'd1, 1'b0);
                produced++;
            end
            else if (ones >= 2 && ones <= MAX_SEQ && !eot)
            begin
                open_len = CNT_W'(ones);
                open_taken = 3'd1;
                open_value = CP_W'(b & (8'h7F >> ones));
            end
            else
            begin
                push_expected(REPLACEMENT, 3'd1, 1'b1);
                produced++;
            end
        end
        if (produced > 0)
        begin
            tail = cp_expected.pop_back();
            tail.last = 1'b1;
            cp_expected.push_back(tail);
        end
    endtask

    // Valid stays high after the beat so back-to-back bytes never lower and
    // raise it in the same step; it drops only when a gap begins or after the last text.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        predict_code_points(b, eot);
        bytes_sent++;
    endtask

    // Sends the first count bytes of a random character of len bytes.
    task automatic send_char(input int len, input int count, input logic eot_last);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < count; i++)
        begin
            if (i != 0)
                b = 8'h80 | 8'($urandom_range(0, 63));
            else if (len == 1)
                b = 8'($urandom_range(0, 127));
            else
                b = (8'hFF << (8 - len)) | (8'($urandom) & (8'h7F >> len));
            send_byte(b, eot_last && (i == count - 1));
        end
    endtask

    // Receiver: random stall runs, with a long hold when a test asks for one.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                cp_stall <= 1'b1;
            end
            else if (no_idle || $urandom_range(0, 99) < 65)
            begin
                cp_stall <= 1'b0;
            end
            else
            begin
                cp_stall <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cp_valid && !cp_stall)
        begin
            if (cp_expected.size() == 0)
            begin
                $error("code_point: no result expected, got %h", code_point);
                mismatches++;
            end
            else
            begin
                want = cp_expected.pop_front();
                if (code_point !== want.value)
                begin
                    $error("code_point: expected %h, actual %h", want.value, code_point);
                    mismatches++;
                end
                if (byte_count !== want.count)
                begin
                    $error("byte_count: expected %0d, actual %0d", want.count, byte_count);
                    mismatches++;
                end
                if (is_error !== want.err)
                begin
                    $error("is_error: expected %b, actual %b", want.err, is_error);
                    mismatches++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %b, actual %b", want.last, last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // ASCII extremes, lone continuations and bytes with too many leading ones.
    task automatic test_single_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Shortest and longest sequences, the smallest and the largest value.
    task automatic test_full_sequences();
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hFD, 1'b0);
        repeat (5) send_byte(8'hBF, 1'b0);
    endtask

    // A sequence cut by ASCII, then one cut by a new lead.
    task automatic test_broken_sequence();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
    endtask

    // Text ending inside a sequence, and a lead arriving as the final byte.
    task automatic test_unfinished_text();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b1);
        send_byte(8'hC3, 1'b1);
    endtask

    // The receiver holds off while six-result bursts keep coming, so the
    // decoder has to stall its input.
    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_request = 300;
        repeat (6)
        begin
            send_char(6, 5, 1'b0);
            send_char(1, 1, 1'b0);
        end
        no_idle = 1'b0;
    endtask

    // Mostly well-formed characters of every length, plus cut sequences,
    // texts ending mid-character and raw noise.
    task automatic test_random_text();
        int target;
        int r;
        int len;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            if ($urandom_range(0, 29) == 0)
                no_idle = !no_idle;
            r = $urandom_range(0, 99);
            len = $urandom_range(2, MAX_SEQ);
            if (r < 60)
            begin
                len = $urandom_range(1, MAX_SEQ);
                send_char(len, len, 1'b0);
            end
            else if (r < 75)
                send_char(len, $urandom_range(1, len - 1), 1'b0);
            else if (r < 85)
                send_char(len, $urandom_range(1, len - 1), 1'b1);
            else
                send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_bytes();
        test_full_sequences();
        test_broken_sequence();
        test_unfinished_text();
        test_backpressure();
        test_random_text();
        byte_valid <= 1'b0;
        while (cp_expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/usd_pkg.sv
src/usd_decode.sv
src/usd_emit.sv
src/utf8_stream_decoder.sv
sim/tb_utf8_stream_decoder.sv
